// ----- design/rcfta_pkg.sv -----
// ----------------------------------------------------------------------------
// rcfta_pkg
// Shared constants, types and command codes of the tile allocator.
// ----------------------------------------------------------------------------
package rcfta_pkg;

    localparam int CAPACITY   = 1024;
    localparam int ENTRIES    = 64;
    localparam int GAPS       = 64;

    localparam int ID_W       = 16;
    localparam int REF_W      = 8;
    localparam int BASE_W     = $clog2(CAPACITY);
    localparam int LEN_W      = BASE_W + 1;
    localparam int SUM_W      = LEN_W + 1;
    localparam int ENT_IDX_W  = $clog2(ENTRIES);
    localparam int GAP_IDX_W  = $clog2(GAPS);
    localparam int GAP_CNT_W  = $clog2(GAPS + 1);
    localparam int ENT_CNT_W  = $clog2(ENTRIES + 1);
    localparam int IDX_W      = (ENT_CNT_W > GAP_CNT_W) ? ENT_CNT_W : GAP_CNT_W;

    localparam logic [REF_W-1:0] REF_MAX = '1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_UNLOAD = 1'b1;

    typedef enum logic [2:0] {
        ST_NEW       = 3'd0,
        ST_SHARED    = 3'd1,
        ST_NOSPACE   = 3'd2,
        ST_TABLEFULL = 3'd3,
        ST_FREED     = 3'd4,
        ST_HELD      = 3'd5,
        ST_NOTFOUND  = 3'd6,
        ST_GAPFULL   = 3'd7
    } status_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_ESCAN,
        CMD_SHARE,
        CMD_HELD,
        CMD_NOTFOUND,
        CMD_TFULL,
        CMD_NOSPACE,
        CMD_GINIT,
        CMD_GSCAN_L,
        CMD_GFIT,
        CMD_TAIL,
        CMD_GSCAN_F,
        CMD_FREE,
        CMD_SHIFT_L,
        CMD_SHIFT_R,
        CMD_FIN_REMOVE,
        CMD_FIN_INSERT,
        CMD_SEND
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [BASE_W-1:0] base;
        logic [LEN_W-1:0]  len;
        logic [REF_W-1:0]  refs;
    } ent_t;

    typedef struct packed {
        logic [BASE_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } gap_t;

    typedef struct packed {
        logic is_unload;
        logic ent_hit;
        logic ent_done;
        logic gap_hit;
        logic gap_done;
        logic shr_done;
        logic hit;
        logic free_vld;
        logic multi_ref;
        logic size_zero;
        logic exact;
        logic at_tail;
        logic join_prev;
        logic join_next;
        logic gap_full;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/rcfta_req_if.sv -----
// ----------------------------------------------------------------------------
// rcfta_req_if
// Request channel: load or unload command with valid/ready.
// ----------------------------------------------------------------------------
interface rcfta_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [15:0] asset_id;
    logic [10:0] size_units;
    logic [9:0]  base_index;

    modport source (output valid, output opcode, output asset_id, output size_units,
                    output base_index, input ready);
    modport sink (input valid, input opcode, input asset_id, input size_units,
                  input base_index, output ready);
endinterface

// ----- design/rcfta_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rcfta_rsp_if
// Response channel: status and region base with valid/ready.
// ----------------------------------------------------------------------------
interface rcfta_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [9:0] region_base;

    modport source (output valid, output status, output region_base, input ready);
    modport sink (input valid, input status, input region_base, output ready);
endinterface

// ----- design/refcounted_first_fit_tile_allocator.sv -----
// ----------------------------------------------------------------------------
// refcounted_first_fit_tile_allocator
// Reference-counted first-fit allocator of a tile store with gap coalescing.
// ----------------------------------------------------------------------------
// One request is in work at a time; the next is taken once the result sits in
// the output register, which may still wait for the sink. A request costs a
// scan of the 64-entry table at one entry per cycle, which ends early on a
// hit, then for a new load or a last unload a scan of the gap list and, when
// a gap is removed or inserted, a shift of the gaps behind it at one per
// cycle. Each table memory has a single read port. No clearing pass runs
// after reset.
// ----------------------------------------------------------------------------
module refcounted_first_fit_tile_allocator
    import rcfta_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    rcfta_req_if.sink   req,
    rcfta_rsp_if.source rsp
);

    cmd_t       cmd;
    dp_status_t st;
    status_t    out_status;

    rcfta_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .st       (st),
        .cmd      (cmd)
    );

    rcfta_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .opcode     (req.opcode),
        .asset_id   (req.asset_id),
        .size_units (req.size_units),
        .base_index (req.base_index),
        .st         (st),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (out_status),
        .out_base   (rsp.region_base)
    );

    assign rsp.status = out_status;

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while a request is in work");

    a_send_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_SEND |=> rsp.valid)
        else $error("result not presented after send");

    a_base_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_NEW) && (rsp.status != ST_SHARED)
            |-> rsp.region_base == '0)
        else $error("region base nonzero for a status without a region");

    a_send_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd == CMD_SEND |-> !rsp.valid || rsp.ready)
        else $error("result overwritten before transfer");

endmodule

// ----- design/rcfta_dp.sv -----
// ----------------------------------------------------------------------------
// rcfta_dp
// Datapath: entry table, gap list, tail pointer, scan counters and the
// output register. Performs one command per cycle.
// ----------------------------------------------------------------------------
module rcfta_dp
    import rcfta_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    input  logic              opcode,
    input  logic [ID_W-1:0]   asset_id,
    input  logic [LEN_W-1:0]  size_units,
    input  logic [BASE_W-1:0] base_index,
    output dp_status_t        st,
    output logic              out_valid,
    input  logic              out_ready,
    output status_t           out_status,
    output logic [BASE_W-1:0] out_base
);

    ent_t                 ent_mem [ENTRIES];
    gap_t                 gap_mem [GAPS];
    logic [ENTRIES-1:0]   ent_valid_reg;

    logic                 req_op_reg;
    logic [ID_W-1:0]      req_id_reg;
    logic [LEN_W-1:0]     req_size_reg;
    logic [BASE_W-1:0]    req_base_reg;

    logic [IDX_W-1:0]     idx_reg;
    logic                 chk_vld_reg;
    logic [IDX_W-1:0]     chk_idx_reg;
    ent_t                 ent_q_reg;
    gap_t                 gap_q_reg;

    logic                 hit_reg;
    logic [ENT_IDX_W-1:0] hit_idx_reg;
    ent_t                 hit_ent_reg;
    logic                 free_vld_reg;
    logic [ENT_IDX_W-1:0] free_idx_reg;

    gap_t                 cur_reg;
    logic                 cur_vld_reg;
    gap_t                 prev_reg;
    logic                 prev_vld_reg;
    logic [GAP_CNT_W-1:0] p_reg;

    logic [GAP_CNT_W-1:0] gap_count_reg;
    logic [LEN_W-1:0]     tail_reg;

    status_t              res_status_reg;
    logic [BASE_W-1:0]    res_base_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [BASE_W-1:0]    out_base_reg;

    logic                 issue;
    logic [IDX_W-1:0]     rd_idx;
    logic [IDX_W-1:0]     gcount_x;
    logic                 ent_match;
    logic                 gap_hit;
    logic [SUM_W-1:0]     end_x;
    logic [SUM_W-1:0]     prev_end;
    logic                 at_tail;
    logic                 join_prev;
    logic                 join_next;
    logic                 gap_full;
    logic                 exact;
    logic                 tail_fits;
    logic                 out_free;

    logic                 ent_we;
    logic [ENT_IDX_W-1:0] ent_wa;
    ent_t                 ent_wd;
    logic                 gap_we;
    logic [GAP_IDX_W-1:0] gap_wa;
    gap_t                 gap_wd;
    ent_t                 new_ent;

    assign gcount_x  = IDX_W'(gap_count_reg);
    assign ent_match = chk_vld_reg && ent_valid_reg[chk_idx_reg[ENT_IDX_W-1:0]]
                       && ((req_op_reg == OP_LOAD) ? (ent_q_reg.id == req_id_reg)
                                                   : (ent_q_reg.base == req_base_reg));
    assign gap_hit   = chk_vld_reg
                       && ((req_op_reg == OP_LOAD) ? (gap_q_reg.len >= req_size_reg)
                                                   : (gap_q_reg.start >= req_base_reg));
    assign end_x     = SUM_W'(req_base_reg) + SUM_W'(hit_ent_reg.len);
    assign prev_end  = SUM_W'(prev_reg.start) + SUM_W'(prev_reg.len);
    assign at_tail   = end_x == SUM_W'(tail_reg);
    assign join_prev = prev_vld_reg && (prev_end == SUM_W'(req_base_reg));
    assign join_next = cur_vld_reg && (SUM_W'(cur_reg.start) == end_x);
    assign gap_full  = !at_tail && !join_prev && !join_next
                       && (gap_count_reg >= GAP_CNT_W'(GAPS));
    assign exact     = cur_reg.len == req_size_reg;
    assign tail_fits = (SUM_W'(tail_reg) + SUM_W'(req_size_reg)) <= SUM_W'(CAPACITY);
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        st.is_unload = req_op_reg == OP_UNLOAD;
        st.ent_hit   = ent_match;
        st.ent_done  = !chk_vld_reg && (idx_reg == IDX_W'(ENTRIES));
        st.gap_hit   = gap_hit;
        st.gap_done  = !chk_vld_reg && (idx_reg >= gcount_x);
        st.shr_done  = !chk_vld_reg && (idx_reg <= IDX_W'(p_reg));
        st.hit       = hit_reg;
        st.free_vld  = free_vld_reg;
        st.multi_ref = hit_ent_reg.refs > REF_W'(1);
        st.size_zero = req_size_reg == '0;
        st.exact     = exact;
        st.at_tail   = at_tail;
        st.join_prev = join_prev;
        st.join_next = join_next;
        st.gap_full  = gap_full;
        st.out_free  = out_free;
    end

    // read-address sequencing of the scans and shifts
    always_comb
    begin
        issue  = 1'b0;
        rd_idx = idx_reg;
        case (cmd)
            CMD_ESCAN:                           issue = idx_reg < IDX_W'(ENTRIES);
            CMD_GSCAN_L, CMD_GSCAN_F, CMD_SHIFT_L: issue = idx_reg < gcount_x;
            CMD_SHIFT_R:
            begin
                issue  = idx_reg > IDX_W'(p_reg);
                rd_idx = idx_reg - 1'b1;
            end
            default:                             issue = 1'b0;
        endcase
    end

    always_comb
    begin
        new_ent.id   = req_id_reg;
        new_ent.base = cur_reg.start;
        new_ent.len  = req_size_reg;
        new_ent.refs = REF_W'(1);
        ent_we = 1'b0;
        ent_wa = hit_idx_reg;
        ent_wd = hit_ent_reg;
        gap_we = 1'b0;
        gap_wa = p_reg[GAP_IDX_W-1:0];
        gap_wd = cur_reg;
        case (cmd)
            CMD_SHARE:
            begin
                ent_we = 1'b1;
                if (hit_ent_reg.refs != REF_MAX)
                begin
                    ent_wd.refs = hit_ent_reg.refs + 1'b1;
                end
            end
            CMD_HELD:
            begin
                ent_we      = 1'b1;
                ent_wd.refs = hit_ent_reg.refs - 1'b1;
            end
            CMD_GFIT:
            begin
                ent_we = 1'b1;
                ent_wa = free_idx_reg;
                ent_wd = new_ent;
                if (!exact)
                begin
                    gap_we       = 1'b1;
                    gap_wd.start = BASE_W'(SUM_W'(cur_reg.start) + SUM_W'(req_size_reg));
                    gap_wd.len   = cur_reg.len - req_size_reg;
                end
            end
            CMD_TAIL:
            begin
                ent_we      = tail_fits;
                ent_wa      = free_idx_reg;
                ent_wd      = new_ent;
                ent_wd.base = tail_reg[BASE_W-1:0];
            end
            CMD_FREE:
            begin
                if (!gap_full && !at_tail)
                begin
                    if (join_prev)
                    begin
                        gap_we       = 1'b1;
                        gap_wa       = GAP_IDX_W'(p_reg - 1'b1);
                        gap_wd.start = prev_reg.start;
                        if (join_next)
                        begin
                            gap_wd.len = prev_reg.len + hit_ent_reg.len + cur_reg.len;
                        end
                        else
                        begin
                            gap_wd.len = prev_reg.len + hit_ent_reg.len;
                        end
                    end
                    else if (join_next)
                    begin
                        gap_we       = 1'b1;
                        gap_wd.start = req_base_reg;
                        gap_wd.len   = cur_reg.len + hit_ent_reg.len;
                    end
                end
            end
            CMD_SHIFT_L:
            begin
                gap_we = chk_vld_reg;
                gap_wa = GAP_IDX_W'(chk_idx_reg - 1'b1);
                gap_wd = gap_q_reg;
            end
            CMD_SHIFT_R:
            begin
                gap_we = chk_vld_reg;
                gap_wa = GAP_IDX_W'(chk_idx_reg + 1'b1);
                gap_wd = gap_q_reg;
            end
            CMD_FIN_INSERT:
            begin
                gap_we       = 1'b1;
                gap_wd.start = req_base_reg;
                gap_wd.len   = hit_ent_reg.len;
            end
            default:
            begin
                ent_we = 1'b0;
                gap_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_q_reg <= ent_mem[rd_idx[ENT_IDX_W-1:0]];
        gap_q_reg <= gap_mem[rd_idx[GAP_IDX_W-1:0]];
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (gap_we)
        begin
            gap_mem[gap_wa] <= gap_wd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= '0;
            idx_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_vld_reg  <= 1'b0;
            cur_vld_reg   <= 1'b0;
            prev_vld_reg  <= 1'b0;
            gap_count_reg <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            chk_vld_reg <= issue;
            if (issue)
            begin
                idx_reg <= (cmd == CMD_SHIFT_R) ? idx_reg - 1'b1 : idx_reg + 1'b1;
            end
            if (out_valid_reg && out_ready && (cmd != CMD_SEND))
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_CAPTURE:
                begin
                    idx_reg      <= '0;
                    hit_reg      <= 1'b0;
                    free_vld_reg <= 1'b0;
                end
                CMD_ESCAN:
                begin
                    if (ent_match)
                    begin
                        hit_reg <= 1'b1;
                    end
                    else if (chk_vld_reg && !ent_valid_reg[chk_idx_reg[ENT_IDX_W-1:0]])
                    begin
                        free_vld_reg <= 1'b1;
                    end
                end
                CMD_GINIT:
                begin
                    idx_reg      <= '0;
                    cur_vld_reg  <= 1'b0;
                    prev_vld_reg <= 1'b0;
                end
                CMD_GSCAN_L:
                begin
                    if (gap_hit)
                    begin
                        cur_vld_reg <= 1'b1;
                    end
                end
                CMD_GSCAN_F:
                begin
                    if (gap_hit)
                    begin
                        cur_vld_reg <= 1'b1;
                    end
                    else if (chk_vld_reg)
                    begin
                        prev_vld_reg <= 1'b1;
                    end
                end
                CMD_GFIT:
                begin
                    ent_valid_reg[free_idx_reg] <= 1'b1;
                    idx_reg <= IDX_W'(p_reg) + 1'b1;
                end
                CMD_TAIL:
                begin
                    if (tail_fits)
                    begin
                        ent_valid_reg[free_idx_reg] <= 1'b1;
                        tail_reg <= tail_reg + req_size_reg;
                    end
                end
                CMD_FREE:
                begin
                    if (!gap_full)
                    begin
                        ent_valid_reg[hit_idx_reg] <= 1'b0;
                        if (at_tail)
                        begin
                            // pull the tail back over a gap that ends at the region
                            if (join_prev)
                            begin
                                tail_reg      <= LEN_W'(prev_reg.start);
                                gap_count_reg <= gap_count_reg - 1'b1;
                            end
                            else
                            begin
                                tail_reg <= LEN_W'(req_base_reg);
                            end
                        end
                        else if (join_prev && join_next)
                        begin
                            idx_reg <= IDX_W'(p_reg) + 1'b1;
                        end
                        else
                        begin
                            idx_reg <= gcount_x;
                        end
                    end
                end
                CMD_FIN_REMOVE: gap_count_reg <= gap_count_reg - 1'b1;
                CMD_FIN_INSERT: gap_count_reg <= gap_count_reg + 1'b1;
                CMD_SEND:       out_valid_reg <= 1'b1;
                default:        hit_reg <= hit_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= rd_idx;
        case (cmd)
            CMD_CAPTURE:
            begin
                req_op_reg   <= opcode;
                req_id_reg   <= asset_id;
                req_size_reg <= size_units;
                req_base_reg <= base_index;
            end
            CMD_ESCAN:
            begin
                if (ent_match)
                begin
                    hit_idx_reg <= chk_idx_reg[ENT_IDX_W-1:0];
                    hit_ent_reg <= ent_q_reg;
                end
                else if (chk_vld_reg && !free_vld_reg
                         && !ent_valid_reg[chk_idx_reg[ENT_IDX_W-1:0]])
                begin
                    free_idx_reg <= chk_idx_reg[ENT_IDX_W-1:0];
                end
            end
            CMD_GINIT: p_reg <= gap_count_reg;
            CMD_GSCAN_L, CMD_GSCAN_F:
            begin
                if (gap_hit)
                begin
                    p_reg   <= GAP_CNT_W'(chk_idx_reg);
                    cur_reg <= gap_q_reg;
                end
                else if (chk_vld_reg)
                begin
                    prev_reg <= gap_q_reg;
                end
            end
            CMD_SHARE:
            begin
                res_status_reg <= ST_SHARED;
                res_base_reg   <= hit_ent_reg.base;
            end
            CMD_HELD:
            begin
                res_status_reg <= ST_HELD;
                res_base_reg   <= '0;
            end
            CMD_NOTFOUND:
            begin
                res_status_reg <= ST_NOTFOUND;
                res_base_reg   <= '0;
            end
            CMD_TFULL:
            begin
                res_status_reg <= ST_TABLEFULL;
                res_base_reg   <= '0;
            end
            CMD_NOSPACE:
            begin
                res_status_reg <= ST_NOSPACE;
                res_base_reg   <= '0;
            end
            CMD_GFIT:
            begin
                res_status_reg <= ST_NEW;
                res_base_reg   <= cur_reg.start;
            end
            CMD_TAIL:
            begin
                res_status_reg <= tail_fits ? ST_NEW : ST_NOSPACE;
                res_base_reg   <= tail_fits ? tail_reg[BASE_W-1:0] : '0;
            end
            CMD_FREE:
            begin
                res_status_reg <= gap_full ? ST_GAPFULL : ST_FREED;
                res_base_reg   <= '0;
            end
            CMD_SEND:
            begin
                out_status_reg <= res_status_reg;
                out_base_reg   <= res_base_reg;
            end
            default:
            begin
                res_base_reg <= res_base_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_base   = out_base_reg;

endmodule

// ----- design/rcfta_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcfta_ctrl
// Controller: sequences the table scan, gap scan, gap shifts and the result.
// ----------------------------------------------------------------------------
module rcfta_ctrl
    import rcfta_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t st,
    output cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_ESCAN,
        S_EDEC,
        S_SHARE,
        S_HELD,
        S_NOTFOUND,
        S_TFULL,
        S_NOSPACE,
        S_GINIT_L,
        S_GSCAN_L,
        S_GFIT,
        S_TAIL,
        S_GINIT_F,
        S_GSCAN_F,
        S_FDEC,
        S_SHIFT_L,
        S_SHIFT_R,
        S_FIN_RM,
        S_FIN_INS,
        S_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_ESCAN;
                end
            end
            S_ESCAN:
            begin
                cmd = CMD_ESCAN;
                if (st.ent_hit || st.ent_done)
                begin
                    state_next = S_EDEC;
                end
            end
            S_EDEC:
            begin
                if (st.is_unload)
                begin
                    if (!st.hit)
                        state_next = S_NOTFOUND;
                    else if (st.multi_ref)
                        state_next = S_HELD;
                    else
                        state_next = S_GINIT_F;
                end
                else
                begin
                    if (st.hit)
                        state_next = S_SHARE;
                    else if (!st.free_vld)
                        state_next = S_TFULL;
                    else if (st.size_zero)
                        state_next = S_NOSPACE;
                    else
                        state_next = S_GINIT_L;
                end
            end
            S_SHARE:
            begin
                cmd        = CMD_SHARE;
                state_next = S_SEND;
            end
            S_HELD:
            begin
                cmd        = CMD_HELD;
                state_next = S_SEND;
            end
            S_NOTFOUND:
            begin
                cmd        = CMD_NOTFOUND;
                state_next = S_SEND;
            end
            S_TFULL:
            begin
                cmd        = CMD_TFULL;
                state_next = S_SEND;
            end
            S_NOSPACE:
            begin
                cmd        = CMD_NOSPACE;
                state_next = S_SEND;
            end
            S_GINIT_L:
            begin
                cmd        = CMD_GINIT;
                state_next = S_GSCAN_L;
            end
            S_GSCAN_L:
            begin
                cmd = CMD_GSCAN_L;
                if (st.gap_hit)
                    state_next = S_GFIT;
                else if (st.gap_done)
                    state_next = S_TAIL;
            end
            S_GFIT:
            begin
                cmd        = CMD_GFIT;
                state_next = st.exact ? S_SHIFT_L : S_SEND;
            end
            S_TAIL:
            begin
                cmd        = CMD_TAIL;
                state_next = S_SEND;
            end
            S_GINIT_F:
            begin
                cmd        = CMD_GINIT;
                state_next = S_GSCAN_F;
            end
            S_GSCAN_F:
            begin
                cmd = CMD_GSCAN_F;
                if (st.gap_hit || st.gap_done)
                    state_next = S_FDEC;
            end
            S_FDEC:
            begin
                cmd = CMD_FREE;
                if (st.gap_full || st.at_tail)
                    state_next = S_SEND;
                else if (st.join_prev && st.join_next)
                    state_next = S_SHIFT_L;
                else if (st.join_prev || st.join_next)
                    state_next = S_SEND;
                else
                    state_next = S_SHIFT_R;
            end
            S_SHIFT_L:
            begin
                cmd = CMD_SHIFT_L;
                if (st.gap_done)
                    state_next = S_FIN_RM;
            end
            S_SHIFT_R:
            begin
                cmd = CMD_SHIFT_R;
                if (st.shr_done)
                    state_next = S_FIN_INS;
            end
            S_FIN_RM:
            begin
                cmd        = CMD_FIN_REMOVE;
                state_next = S_SEND;
            end
            S_FIN_INS:
            begin
                cmd        = CMD_FIN_INSERT;
                state_next = S_SEND;
            end
            S_SEND:
            begin
                // hold until the output register is free
                if (st.out_free)
                begin
                    cmd        = CMD_SEND;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;

endmodule
